### rtl/rgb_pixel_color_filter_assert.svh
// Assertion macros for the checker file of the pixel color filter.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef RGB_PIXEL_COLOR_FILTER_ASSERT_SVH
`define RGB_PIXEL_COLOR_FILTER_ASSERT_SVH

// Concurrent assertion sampled on the rising clock edge, switched off during reset.
`define RPCF_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, checked during reset too.
`define RPCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rpcf_pkg.sv
// Shared types, constants and helper functions of the pixel color filter.
// Depends on nothing; used by the top level and by its checker.
`default_nettype none

package rpcf_pkg;

   // Channel and register widths.
   localparam int unsigned CHAN_W = 8;
   localparam int unsigned MODE_W = 4;
   localparam int unsigned SUM_W  = CHAN_W + 2;

   localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

   // Filter selection codes held in the mode register; other codes pass through.
   typedef enum logic [MODE_W-1:0] {
      MODE_PASS     = 4'd0,
      MODE_GRAY     = 4'd1,
      MODE_INVERT   = 4'd2,
      MODE_ROTATE   = 4'd3,
      MODE_INV_RED  = 4'd4,
      MODE_INV_GRN  = 4'd5,
      MODE_INV_BLU  = 4'd6,
      MODE_SILLY    = 4'd7,
      MODE_SEPIA    = 4'd8
   } mode_type;

   // Division of a channel sum by three: multiply by 683 and shift by 11.
   // The result is exact for every sum below 2048.
   localparam int unsigned GRAY_RECIP_W = 10;
   localparam logic [GRAY_RECIP_W-1:0] GRAY_RECIP = 10'd683;
   localparam int unsigned GRAY_SHIFT = 11;
   localparam int unsigned GRAY_PROD_W = SUM_W + GRAY_RECIP_W;

   // Sepia coefficients in Q0.10. The second and third inputs of each row are
   // both the gray level, so their coefficients are folded into one.
   localparam int unsigned COEF_W  = 10;
   localparam int unsigned Q_SHIFT = 10;
   localparam int unsigned ACC_W   = 19;

   localparam logic [COEF_W-1:0] SEPIA_RED_INV  = 10'd402;
   localparam logic [COEF_W-1:0] SEPIA_RED_GRAY = 10'd981;
   localparam logic [COEF_W-1:0] SEPIA_GRN_INV  = 10'd357;
   localparam logic [COEF_W-1:0] SEPIA_GRN_GRAY = 10'd874;
   localparam logic [COEF_W-1:0] SEPIA_BLU_INV  = 10'd279;
   localparam logic [COEF_W-1:0] SEPIA_BLU_GRAY = 10'd681;

   // Truncated average of three channels.
   function automatic logic [CHAN_W-1:0] gray_avg(
      input logic [CHAN_W-1:0] red,
      input logic [CHAN_W-1:0] green,
      input logic [CHAN_W-1:0] blue
   );
      logic [SUM_W-1:0]       sum;
      logic [GRAY_PROD_W-1:0] prod;
      sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
      prod = GRAY_PROD_W'(sum) * GRAY_PROD_W'(GRAY_RECIP);
      return prod[GRAY_SHIFT +: CHAN_W];
   endfunction

   // One row of the sepia matrix: weighted sum, truncate, saturate at full scale.
   function automatic logic [CHAN_W-1:0] sepia_row(
      input logic [COEF_W-1:0] coef_inv,
      input logic [COEF_W-1:0] coef_gray,
      input logic [CHAN_W-1:0] inv_red,
      input logic [CHAN_W-1:0] gray
   );
      logic [ACC_W-1:0] acc;
      acc = ACC_W'(coef_inv) * ACC_W'(inv_red) + ACC_W'(coef_gray) * ACC_W'(gray);
      if (acc[ACC_W-1]) begin
         return CHAN_MAX;
      end else begin
         return acc[Q_SHIFT +: CHAN_W];
      end
   endfunction

endpackage

`default_nettype wire

### rtl/rgb_pixel_color_filter.sv
// Per-pixel RGB color filter with a mode register, three register stages deep.
// Depends on rpcf_pkg for mode codes, constants and the arithmetic helpers.
`default_nettype none

// How to use this block:
// A pixel transaction is taken at every rising clock edge where start is high
// and busy is low. Busy is high only while reset is asserted, so outside reset
// one pixel can be taken in every cycle.
// The filtered pixel is on the rsp_ ports with rsp_valid high for exactly one
// cycle, once it has passed the input register, the register after the gray
// average and the result register.
// Throughput is one pixel per clock; pixels leave in the order they arrived.
// The receiver cannot stall the output, so no back-pressure is ever applied.
// The mode register is written through csr_wr_en and csr_wr_data. Write it only
// while no pixel is in flight, since the result stage reads it directly.
// Codes beyond the sepia filter pass the pixel through unchanged.
// Synchronous reset empties the pipeline and sets the mode to pass-through.
module rgb_pixel_color_filter (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [rpcf_pkg::CHAN_W-1:0]  req_red_in,
   input  wire  [rpcf_pkg::CHAN_W-1:0]  req_green_in,
   input  wire  [rpcf_pkg::CHAN_W-1:0]  req_blue_in,
   input  wire                          csr_wr_en,
   input  wire  [rpcf_pkg::MODE_W-1:0]  csr_wr_data,
   output logic                         rsp_valid,
   output logic [rpcf_pkg::CHAN_W-1:0]  rsp_red_out,
   output logic [rpcf_pkg::CHAN_W-1:0]  rsp_green_out,
   output logic [rpcf_pkg::CHAN_W-1:0]  rsp_blue_out
);
   import rpcf_pkg::*;

   logic              accept;
   logic [MODE_W-1:0] mode_ff;

   // Input stage.
   logic              in_valid_ff;
   logic [CHAN_W-1:0] in_red_ff;
   logic [CHAN_W-1:0] in_green_ff;
   logic [CHAN_W-1:0] in_blue_ff;

   // Middle stage, with the gray level already formed.
   logic              mid_valid_ff;
   logic [CHAN_W-1:0] mid_red_ff;
   logic [CHAN_W-1:0] mid_green_ff;
   logic [CHAN_W-1:0] mid_blue_ff;
   logic [CHAN_W-1:0] mid_gray_ff;
   logic [CHAN_W-1:0] mid_gray_in;

   // Result stage.
   logic              out_valid_ff;
   logic [CHAN_W-1:0] out_red_ff;
   logic [CHAN_W-1:0] out_green_ff;
   logic [CHAN_W-1:0] out_blue_ff;
   logic [CHAN_W-1:0] out_red_in;
   logic [CHAN_W-1:0] out_green_in;
   logic [CHAN_W-1:0] out_blue_in;

   logic [CHAN_W-1:0] inv_red;
   logic [CHAN_W-1:0] inv_green;
   logic [CHAN_W-1:0] inv_blue;

   // The pipeline never stalls, so the block is only busy in reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= accept;
         mid_valid_ff <= in_valid_ff;
         out_valid_ff <= mid_valid_ff;
      end
   end

   // Capture the incoming transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_red_ff   <= req_red_in;
         in_green_ff <= req_green_in;
         in_blue_ff  <= req_blue_in;
      end
   end

   // The gray average is a constant multiply, registered before the sepia matrix.
   assign mid_gray_in = gray_avg(in_red_ff, in_green_ff, in_blue_ff);

   always_ff @(posedge clock) begin
      mid_red_ff   <= in_red_ff;
      mid_green_ff <= in_green_ff;
      mid_blue_ff  <= in_blue_ff;
      mid_gray_ff  <= mid_gray_in;
   end

   assign inv_red   = CHAN_MAX - mid_red_ff;
   assign inv_green = CHAN_MAX - mid_green_ff;
   assign inv_blue  = CHAN_MAX - mid_blue_ff;

   // Select the filter output for the current mode.
   always_comb begin
      out_red_in   = mid_red_ff;
      out_green_in = mid_green_ff;
      out_blue_in  = mid_blue_ff;
      unique case (mode_ff)
         MODE_GRAY: begin
            out_red_in   = mid_gray_ff;
            out_green_in = mid_gray_ff;
            out_blue_in  = mid_gray_ff;
         end
         MODE_INVERT: begin
            out_red_in   = inv_red;
            out_green_in = inv_green;
            out_blue_in  = inv_blue;
         end
         MODE_ROTATE: begin
            out_red_in   = mid_green_ff;
            out_green_in = mid_blue_ff;
            out_blue_in  = mid_red_ff;
         end
         MODE_INV_RED: begin
            out_red_in = inv_red;
         end
         MODE_INV_GRN: begin
            out_green_in = inv_green;
         end
         MODE_INV_BLU: begin
            out_blue_in = inv_blue;
         end
         MODE_SILLY: begin
            out_red_in   = inv_red;
            out_green_in = mid_gray_ff;
            out_blue_in  = mid_gray_ff;
         end
         MODE_SEPIA: begin
            out_red_in   = sepia_row(SEPIA_RED_INV, SEPIA_RED_GRAY, inv_red, mid_gray_ff);
            out_green_in = sepia_row(SEPIA_GRN_INV, SEPIA_GRN_GRAY, inv_red, mid_gray_ff);
            out_blue_in  = sepia_row(SEPIA_BLU_INV, SEPIA_BLU_GRAY, inv_red, mid_gray_ff);
         end
         default: begin
            out_red_in   = mid_red_ff;
            out_green_in = mid_green_ff;
            out_blue_in  = mid_blue_ff;
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_red_ff;
   assign rsp_green_out = out_green_ff;
   assign rsp_blue_out  = out_blue_ff;

endmodule

`default_nettype wire

### rtl/rpcf_checker.sv
// Port-level checker for the pixel color filter, bound to the top level.
// Depends on rpcf_pkg and on the assertion macros in rgb_pixel_color_filter_assert.svh.
`default_nettype none

`include "rgb_pixel_color_filter_assert.svh"

module rpcf_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire  [rpcf_pkg::CHAN_W-1:0]  req_red_in,
   input wire                          csr_wr_en,
   input wire  [rpcf_pkg::MODE_W-1:0]  csr_wr_data,
   input wire                          rsp_valid,
   input wire  [rpcf_pkg::CHAN_W-1:0]  rsp_red_out,
   input wire  [rpcf_pkg::CHAN_W-1:0]  rsp_green_out,
   input wire  [rpcf_pkg::CHAN_W-1:0]  rsp_blue_out
);
   import rpcf_pkg::*;

   logic [MODE_W-1:0] mode_seen_ff;

   // Shadow of the mode register, tracked from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_seen_ff <= MODE_PASS;
      end else if (csr_wr_en) begin
         mode_seen_ff <= csr_wr_data;
      end
   end

   // Every accepted transaction produces a result.
   `RPCF_ASSERT_RST(a_result_follows, clock, reset, (start && !busy) |-> ##3 rsp_valid, "accepted pixel produced no result")

   // No result appears without an earlier accepted transaction.
   `RPCF_ASSERT_RST(a_no_spurious, clock, reset, rsp_valid |-> $past(start && !busy, 3), "result without an accepted pixel")

   // Grayscale results carry the same value on all three channels.
   `RPCF_ASSERT_RST(a_gray_equal, clock, reset, (rsp_valid && mode_seen_ff == MODE_GRAY) |-> (rsp_red_out == rsp_green_out && rsp_green_out == rsp_blue_out), "grayscale channels differ")

   // Full inversion complements the red channel of the pixel that the result belongs to.
   `RPCF_ASSERT_RST(a_invert_red, clock, reset, (rsp_valid && mode_seen_ff == MODE_INVERT) |-> (rsp_red_out == ~$past(req_red_in, 3)), "inverted red channel is wrong")

endmodule

bind rgb_pixel_color_filter rpcf_checker u_rpcf_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_red_in    (req_red_in),
   .csr_wr_en     (csr_wr_en),
   .csr_wr_data   (csr_wr_data),
   .rsp_valid     (rsp_valid),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out)
);

`default_nettype wire

### tb/sv/rgb_pixel_color_filter_tb.sv
// Self-checking testbench of the RGB pixel color filter: it drives pixels and mode writes.
// It predicts every filtered pixel and compares each result with the oldest expectation.
// Depends on rpcf_pkg and on the rgb_pixel_color_filter top level.
`timescale 1ns / 1ps

module rgb_pixel_color_filter_tb;
   import rpcf_pkg::*;

   // One pixel: three unsigned channels.
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_pixel_type;

   // Pipeline depth of the block, and the stall limit of the watchdog.
   localparam int unsigned PIPE_LATENCY = 3;
   localparam int unsigned STALL_LIMIT  = 500;
   localparam int unsigned MAX_REPORTS  = 10;

   // Number of random phases and of pixels in each.
   localparam int unsigned RANDOM_PHASES = 19;
   localparam int unsigned PHASE_PIXELS  = 100;

   // Sender idle rates in percent, one per phase type.
   localparam int unsigned IDLE_NONE  = 0;
   localparam int unsigned IDLE_HEAVY = 51;
   localparam int unsigned IDLE_LIGHT = 7;

   // Sepia matrix in Q0.10, one row per output channel.
   localparam int unsigned SEPIA_RR = 402, SEPIA_RG = 787, SEPIA_RB = 194;
   localparam int unsigned SEPIA_GR = 357, SEPIA_GG = 702, SEPIA_GB = 172;
   localparam int unsigned SEPIA_BR = 279, SEPIA_BG = 547, SEPIA_BB = 134;
   localparam int unsigned SEPIA_SHIFT = 10;
   localparam int unsigned FULL_SCALE  = 255;

   // Holds the current mode and the filtered pixels still owed by the block.
   class pixel_filter_scoreboard;
      logic [MODE_W-1:0] mode;
      rgb_pixel_type     expected_pixels[$];
      int unsigned       failures;

      function new();
         mode     = MODE_PASS;
         failures = 0;
      endfunction

      function void clear_mode();
         mode = MODE_PASS;
      endfunction

      function void set_mode(logic [MODE_W-1:0] value);
         mode = value;
      endfunction

      // Weighted sum of one sepia row, truncated and then saturated.
      function logic [CHAN_W-1:0] sepia_channel(int unsigned k_inv, int unsigned k_g,
                                                int unsigned k_b, int unsigned inv_red,
                                                int unsigned avg);
         int unsigned acc;
         acc = (k_inv * inv_red + k_g * avg + k_b * avg) >> SEPIA_SHIFT;
         return (acc > FULL_SCALE) ? CHAN_MAX : acc[CHAN_W-1:0];
      endfunction

      // Filtered pixel for the current mode; unknown codes pass the pixel through.
      function rgb_pixel_type filter_pixel(rgb_pixel_type px);
         rgb_pixel_type result;
         int unsigned   avg;
         int unsigned   inv_red;
         result  = px;
         avg     = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
         inv_red = FULL_SCALE - px.red;
         case (mode)
            MODE_GRAY: begin
               result = '{avg[CHAN_W-1:0], avg[CHAN_W-1:0], avg[CHAN_W-1:0]};
            end
            MODE_INVERT: begin
               result = '{CHAN_MAX - px.red, CHAN_MAX - px.green, CHAN_MAX - px.blue};
            end
            MODE_ROTATE: begin
               result = '{px.green, px.blue, px.red};
            end
            MODE_INV_RED: begin
               result.red = CHAN_MAX - px.red;
            end
            MODE_INV_GRN: begin
               result.green = CHAN_MAX - px.green;
            end
            MODE_INV_BLU: begin
               result.blue = CHAN_MAX - px.blue;
            end
            MODE_SILLY: begin
               result = '{CHAN_MAX - px.red, avg[CHAN_W-1:0], avg[CHAN_W-1:0]};
            end
            MODE_SEPIA: begin
               result.red   = sepia_channel(SEPIA_RR, SEPIA_RG, SEPIA_RB, inv_red, avg);
               result.green = sepia_channel(SEPIA_GR, SEPIA_GG, SEPIA_GB, inv_red, avg);
               result.blue  = sepia_channel(SEPIA_BR, SEPIA_BG, SEPIA_BB, inv_red, avg);
            end
            default: begin
               result = px;
            end
         endcase
         return result;
      endfunction

      // A pixel transaction was taken: queue its filtered value.
      function void note_pixel(rgb_pixel_type px);
         expected_pixels.push_back(filter_pixel(px));
      endfunction

      // A result transaction arrived: compare it with the oldest expectation.
      function void check_pixel(rgb_pixel_type actual);
         rgb_pixel_type expected;
         if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("Unexpected result r=%0d g=%0d b=%0d",
                        actual.red, actual.green, actual.blue);
            end
            return;
         end
         expected = expected_pixels.pop_front();
         if (actual.red !== expected.red || actual.green !== expected.green ||
             actual.blue !== expected.blue) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("Mismatch mode=%0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        mode, expected.red, expected.green, expected.blue,
                        actual.red, actual.green, actual.blue);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      // Expectations that never got a result count as failures.
      function void report_leftover();
         if (expected_pixels.size() != 0) begin
            $display("%0d expected results never arrived", expected_pixels.size());
            failures += expected_pixels.size();
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CHAN_W-1:0] req_red_in;
   logic [CHAN_W-1:0] req_green_in;
   logic [CHAN_W-1:0] req_blue_in;
   logic              csr_wr_en;
   logic [MODE_W-1:0] csr_wr_data;
   logic              rsp_valid;
   logic [CHAN_W-1:0] rsp_red_out;
   logic [CHAN_W-1:0] rsp_green_out;
   logic [CHAN_W-1:0] rsp_blue_out;

   pixel_filter_scoreboard scoreboard = new();
   int unsigned            stall_cycles = 0;

   rgb_pixel_color_filter dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

   // Free-running clock, 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Monitor: mode writes, pixel transactions and result transactions, plus the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         scoreboard.clear_mode();
         stall_cycles <= 0;
      end else begin
         if (csr_wr_en) begin
            scoreboard.set_mode(csr_wr_data);
         end
         if (start && !busy) begin
            scoreboard.note_pixel({req_red_in, req_green_in, req_blue_in});
         end
         if (rsp_valid) begin
            scoreboard.check_pixel({rsp_red_out, rsp_green_out, rsp_blue_out});
         end
         if (csr_wr_en || (start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Corner pixels used by the directed part.
   function automatic rgb_pixel_type corner_pixel(int unsigned idx);
      case (idx % 6)
         0: return '{8'h00, 8'h00, 8'h00};
         1: return '{8'hFF, 8'hFF, 8'hFF};
         2: return '{8'h00, 8'hFF, 8'hFF};
         3: return '{8'hFF, 8'h00, 8'h00};
         4: return '{8'hAA, 8'h55, 8'h0F};
         default: return '{8'h01, 8'h02, 8'hFE};
      endcase
   endfunction

   // A channel value: mostly uniform, sometimes pinned to an end of the range.
   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return CHAN_MAX;
         default: return CHAN_W'($urandom_range(0, FULL_SCALE));
      endcase
   endfunction

   // Write the mode register for one cycle.
   task automatic write_mode(logic [MODE_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Offer one pixel after a random gap and hold it until it is taken.
   task automatic send_pixel(rgb_pixel_type px, int unsigned idle_pct);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_red_in   <= px.red;
      req_green_in <= px.green;
      req_blue_in  <= px.blue;
      do @(posedge clock); while (busy);
   endtask

   // Stop offering pixels and let the pipeline empty before a mode change.
   task automatic settle_pipeline();
      @(negedge clock);
      start <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Stimulus: reset, directed corners under every mode, then random phases.
   initial begin
      logic [MODE_W-1:0] directed_modes [11];
      logic [MODE_W-1:0] phase_mode;
      int unsigned       idle_pct;
      rgb_pixel_type     px;

      reset        = 1'b1;
      start        = 1'b0;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      directed_modes = '{MODE_PASS, MODE_GRAY, MODE_INVERT, MODE_ROTATE, MODE_INV_RED,
                         MODE_INV_GRN, MODE_INV_BLU, MODE_SILLY, MODE_SEPIA,
                         4'(MODE_SEPIA + 1), {MODE_W{1'b1}}};
      // Hold reset, then release it at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Two corner pixels per mode, including the undefined codes that pass through.
      for (int unsigned i = 0; i < 11; i++) begin
         write_mode(directed_modes[i]);
         send_pixel(corner_pixel(2 * i), IDLE_NONE);
         send_pixel(corner_pixel(2 * i + 1), IDLE_NONE);
         // Sepia also gets the pixel that drives the red row into saturation.
         if (directed_modes[i] == MODE_SEPIA) begin
            send_pixel(corner_pixel(2), IDLE_NONE);
         end
         settle_pipeline();
      end

      // Random phases: the first ones cover the extreme modes, later ones lean to sepia.
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: phase_mode = MODE_SEPIA;
            1: phase_mode = MODE_PASS;
            2: phase_mode = {MODE_W{1'b1}};
            default: begin
               phase_mode = ($urandom_range(0, 3) == 0) ? MODE_SEPIA :
                                                           MODE_W'($urandom_range(0, 15));
            end
         endcase
         case (phase % 3)
            0: idle_pct = IDLE_NONE;
            1: idle_pct = IDLE_HEAVY;
            default: idle_pct = IDLE_LIGHT;
         endcase
         write_mode(phase_mode);
         for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
            px = '{random_channel(), random_channel(), random_channel()};
            send_pixel(px, idle_pct);
         end
         settle_pipeline();
      end

      scoreboard.report_leftover();
      if (scoreboard.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
